### rtl/nps_pkg.sv
package nps_pkg;

  // default search width, sign bit included
  localparam int NPS_DATA_WIDTH = 32;

  // answer for every start value at or below it
  localparam int NPS_SMALLEST_PRIME = 2;

  // first odd trial divisor
  localparam int NPS_FIRST_DIVISOR = 3;

endpackage

### rtl/nps_div.sv
module nps_div #(
  parameter int W = nps_pkg::NPS_DATA_WIDTH - 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic          ge;

  // restoring step: one quotient bit per cycle
  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[W-2:0], ge};
      rem_nxt = ge ? W'(trial - {1'b0, den_r}) : trial[W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/next_prime_search.sv
// next_prime_search: smallest prime at or above a signed start value
//
// input channel: in_valid / in_stall carry in_start_value, a signed word of
// DATA_WIDTH bits. result channel: out_valid / out_stall carry out_next_prime,
// DATA_WIDTH-1 bits unsigned. a word moves when valid is high and stall low.
// start values of two or less give 2; an even start is raised to the next odd.
// each odd candidate is tested by trial division with odd divisors 3, 5, ...
// until the divisor exceeds the quotient (square root reached) or divides.
// one shared restoring divider does every division, one bit per cycle. each
// trial divisor is an issue in ST_TEST, one restoring step per quotient bit in
// the divider, then the decision in ST_WAIT. start values of two or less go
// straight to the result without any division. one word is handled at a time:
// in_stall stays high from accept until the result has been taken, so no new
// word enters before the last result leaves. a stalled result holds in its
// register.
// if the search would pass 2^(DATA_WIDTH-1)-1 the result saturates to it.
// after reset the block is idle, in_stall low and out_valid low.
module next_prime_search #(
  parameter int DATA_WIDTH = nps_pkg::NPS_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_start_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [DATA_WIDTH-2:0] out_next_prime
);

  import nps_pkg::*;

  localparam int W = DATA_WIDTH - 1;

  localparam logic [W-1:0] TOP_POS  = '1;
  localparam logic [W-1:0] TOP_NEAR = TOP_POS - W'(2);
  localparam logic [W-1:0] TWO      = W'(NPS_SMALLEST_PRIME);
  localparam logic [W-1:0] THREE    = W'(NPS_FIRST_DIVISOR);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TEST = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [W-1:0] cand_r, cand_nxt;
  logic [W-1:0] div_r, div_nxt;
  logic         in_acc, small_start;
  logic         div_start, div_done;
  logic [W-1:0] div_quo, div_rem;

  assign in_acc      = in_valid && !in_stall;
  assign small_start = in_start_value[DATA_WIDTH-1] || (in_start_value[W-1:0] <= TWO);

  nps_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (cand_r),
    .divisor   (div_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    div_nxt   = div_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (small_start) begin
            cand_nxt  = TWO;
            state_nxt = ST_DONE;
          end else begin
            // even start moves up to the odd value just above
            cand_nxt  = {in_start_value[W-1:1], 1'b1};
            div_nxt   = THREE;
            state_nxt = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (div_r > div_quo) begin
            // divisor passed the square root: prime
            state_nxt = ST_DONE;
          end else if (div_rem == '0) begin
            if (cand_r > TOP_NEAR) begin
              state_nxt = ST_DONE;
            end else begin
              cand_nxt  = cand_r + W'(2);
              div_nxt   = THREE;
              state_nxt = ST_TEST;
            end
          end else begin
            div_nxt   = div_r + W'(2);
            state_nxt = ST_TEST;
          end
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    div_r  <= div_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_DONE);
  assign out_next_prime = cand_r;

  // no new word while a result is pending
  a_busy_stall : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // trial divisors are always odd while searching
  a_div_odd : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST || state_r == ST_WAIT) |-> div_r[0])
    else $error("even trial divisor");

  // a result is 2 or odd
  a_result_odd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_prime == TWO || out_next_prime[0]))
    else $error("even result above two");

  // an issued division is still running when ST_WAIT starts, so no decision uses a stale done
  a_div_issue : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST) |=> (state_r == ST_WAIT && !div_done))
    else $error("divider done too early");

endmodule

### tb/sv/tb_next_prime_search.sv
module tb_next_prime_search;
  import nps_pkg::*;

  localparam int W = NPS_DATA_WIDTH;
  localparam logic [W-2:0] TOP_PRIME = {(W-1){1'b1}};
  localparam logic [W-2:0] LOWEST_PRIME = (W-1)'(NPS_SMALLEST_PRIME);
  // the watchdog limit must outlast the trial division of the top positive start
  localparam int WATCHDOG_LIMIT = 3_000_000;
  localparam int RANDOM_WORDS = 80;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [W-1:0] in_start_value = '0;
  logic in_stall;
  logic out_valid;
  logic [W-2:0] out_next_prime;

  typedef struct packed {
    logic signed [W-1:0] start;
    bit                  typed;
    logic [W-2:0]        want;
  } start_row_t;

  // typed rows carry their answer, the rest go through the prime search below
  start_row_t start_rows [0:16] = '{
    '{32'h8000_0000, 1'b1, LOWEST_PRIME},
    '{-32'sd1,       1'b1, LOWEST_PRIME},
    '{-32'sd7,       1'b1, LOWEST_PRIME},
    '{32'sd0,        1'b1, LOWEST_PRIME},
    '{32'sd1,        1'b1, LOWEST_PRIME},
    '{32'sd2,        1'b1, LOWEST_PRIME},
    '{32'sd3,        1'b1, 31'd3},
    '{32'sd4,        1'b1, 31'd5},
    '{32'sd8,        1'b0, '0},
    '{32'sd9,        1'b0, '0},
    '{32'sd24,       1'b0, '0},
    '{32'sd25,       1'b0, '0},
    '{32'sd114,      1'b0, '0},
    '{32'sd1000,     1'b0, '0},
    '{32'sd65536,    1'b0, '0},
    '{32'sd1048573,  1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, TOP_PRIME}
  };

  logic [W-2:0] pending_primes [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int words_sent = 0;
  int negatives_sent = 0;
  int primes_checked = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  next_prime_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_value (in_start_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_prime (out_next_prime)
  );

  function automatic logic [W-2:0] next_prime_of(logic signed [W-1:0] start);
    longint unsigned cand;
    longint unsigned div;
    bit composite;
    if (start <= 2) return LOWEST_PRIME;
    cand = 64'(start);
    if (!cand[0]) cand = cand + 1;
    forever begin
      composite = 1'b0;
      div = 3;
      while (!composite && div <= cand / div) begin
        if (cand % div == 0) composite = 1'b1;
        div = div + 2;
      end
      if (!composite) return cand[W-2:0];
      if (cand > TOP_PRIME - 2) return TOP_PRIME;
      cand = cand + 2;
    end
  endfunction

  // mostly small starts so each search stays short
  function automatic logic signed [W-1:0] random_start();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return {1'b1, (W-1)'($urandom_range(32'h7FFF_FFFF, 0))};
    else if (pick < 35) return $urandom_range(16, 0);
    else if (pick < 88) return $urandom_range(65535, 17);
    else return $urandom_range(262143, 65536);
  endfunction

  task automatic report_mismatch(string what, logic [W-2:0] got, logic [W-2:0] want);
    $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_word(logic signed [W-1:0] start, bit typed, logic [W-2:0] want);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_start_value <= start;
    do @(posedge clk); while (in_stall);
    pending_primes.push_back(typed ? want : next_prime_of(start));
    words_sent++;
    if (start < 0) negatives_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_primes.size() == 0) begin
        report_mismatch("result word with nothing pending", out_next_prime, '0);
      end else begin
        if (out_next_prime !== pending_primes[0])
          report_mismatch("next_prime", out_next_prime, pending_primes[0]);
        void'(pending_primes.pop_front());
        primes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("next_prime_search verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (start_rows[i])
      send_word(start_rows[i].start, start_rows[i].typed, start_rows[i].want);
    drain_results();

    // receiver holds off while words keep coming, so the input side backs up
    // small starts keep each search well inside the hold
    hold_left = HOLD_CYCLES;
    repeat (6) send_word(W'($urandom_range(40, 0)), 1'b0, '0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      repeat (RANDOM_WORDS / 4) send_word(random_start(), 1'b0, '0);
      drain_results();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d start words, %0d of them negative, from the most negative",
             words_sent, negatives_sent);
    $display("to the top positive start; %0d results compared over four idle/stall mixes",
             primes_checked);
    if (errors == 0) begin
      $display("next_prime_search verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("next_prime_search verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/nps_pkg.sv
rtl/nps_div.sv
rtl/next_prime_search.sv
tb/sv/tb_next_prime_search.sv
